/* src/isotp_pci_pkg.sv */
// ----------------------------------------------------------------------------
// ISO-TP PCI decoder package
// Shared transfer types, frame type codes and protocol limits.
// ----------------------------------------------------------------------------
package isotp_pci_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_BAD_FRAME = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FT_SINGLE      = 2'd0,
        FT_FIRST       = 2'd1,
        FT_CONSECUTIVE = 2'd2,
        FT_FLOW        = 2'd3
    } frame_type_t;

    localparam logic [3:0] PCI_SINGLE      = 4'd0;
    localparam logic [3:0] PCI_FIRST       = 4'd1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'd2;
    localparam logic [3:0] PCI_FLOW        = 4'd3;

    localparam logic [6:0]  CLASSIC_BYTES  = 7'd8;
    localparam logic [7:0]  SF_CLASSIC_MAX = 8'd7;
    localparam logic [7:0]  SF_FD_MAX      = 8'd62;
    localparam logic [11:0] FF_CLASSIC_CAP = 12'd7;
    localparam logic [11:0] FF_FD_CAP      = 12'd62;
    localparam logic [6:0]  FF_EXT_HEADER  = 7'd6;
    localparam logic [3:0]  FS_MAX         = 4'd2;
    localparam logic [7:0]  STMIN_MS_MAX   = 8'h7F;
    localparam logic [7:0]  STMIN_US_MIN   = 8'hF1;
    localparam logic [7:0]  STMIN_US_MAX   = 8'hF9;

    localparam logic [2:0] OFF_SHORT = 3'd1;
    localparam logic [2:0] OFF_ESC   = 3'd2;
    localparam logic [2:0] OFF_FLOW  = 3'd3;
    localparam logic [2:0] OFF_EXT   = 3'd6;

    typedef struct packed {
        logic [6:0] frame_length;
        logic [7:0] header_byte0;
        logic [7:0] header_byte1;
        logic [7:0] header_byte2;
        logic [7:0] header_byte3;
        logic [7:0] header_byte4;
        logic [7:0] header_byte5;
    } frame_t;

    typedef struct packed {
        status_t     status;
        frame_type_t frame_type;
        logic [2:0]  data_offset;
        logic [31:0] data_length;
        logic [3:0]  seq_num;
        logic [1:0]  fc_status;
        logic [7:0]  fc_block_limit;
        logic [7:0]  separation_time;
    } result_t;

endpackage

/* src/isotp_pci_decode.sv */
// ----------------------------------------------------------------------------
// ISO-TP PCI decode logic
// Checks one registered frame header and forms its result fields.
// ----------------------------------------------------------------------------
module isotp_pci_decode #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  isotp_pci_pkg::frame_t  frame,
    output isotp_pci_pkg::result_t result
);
    import isotp_pci_pkg::*;

    localparam logic [6:0] MAX_LEN = 7'(MAX_FRAME_BYTES);

    logic [6:0]  len;
    logic [3:0]  nib;
    logic [11:0] len12;
    logic [11:0] ff_cap;
    logic [31:0] ext_len;
    logic        stmin_ok;
    result_t     res;

    assign len     = frame.frame_length;
    assign nib     = frame.header_byte0[3:0];
    assign len12   = {nib, frame.header_byte1};
    assign ff_cap  = (len <= CLASSIC_BYTES) ? FF_CLASSIC_CAP : FF_FD_CAP;
    assign ext_len = {frame.header_byte2, frame.header_byte3,
                      frame.header_byte4, frame.header_byte5};
    assign stmin_ok = (frame.header_byte2 <= STMIN_MS_MAX) ||
                      ((frame.header_byte2 >= STMIN_US_MIN) &&
                       (frame.header_byte2 <= STMIN_US_MAX));

    always_comb
    begin
        res = '0;
        res.status = ST_OK;
        if ((len == 7'd0) || (len > MAX_LEN))
        begin
            res.status = ST_BAD_ARG;
        end
        else
        begin
            case (frame.header_byte0[7:4])
                PCI_SINGLE:
                begin
                    res.frame_type = FT_SINGLE;
                    if (nib != 4'd0)
                    begin
                        res.data_offset = OFF_SHORT;
                        res.data_length = 32'(nib);
                        if ((len > CLASSIC_BYTES) || ({3'd0, nib} > (len - 7'd1)))
                            res.status = ST_BAD_FRAME;
                    end
                    else
                    begin
                        res.data_offset = OFF_ESC;
                        res.data_length = 32'(frame.header_byte1);
                        if ((len < 7'd2) || (frame.header_byte1 <= SF_CLASSIC_MAX) ||
                            (frame.header_byte1 > SF_FD_MAX) ||
                            (frame.header_byte1 > ({1'b0, len} - 8'd2)))
                            res.status = ST_BAD_FRAME;
                    end
                end
                PCI_FIRST:
                begin
                    res.frame_type = FT_FIRST;
                    if (len < 7'd2)
                    begin
                        res.status = ST_BAD_FRAME;
                    end
                    else if (len12 != 12'd0)
                    begin
                        res.data_offset = OFF_ESC;
                        res.data_length = 32'(len12);
                        if ((len12 <= ff_cap) || (len12 <= (12'(len) - 12'd2)))
                            res.status = ST_BAD_FRAME;
                    end
                    else
                    begin
                        res.data_offset = OFF_EXT;
                        res.data_length = ext_len;
                        if ((len < FF_EXT_HEADER) || (ext_len[31:12] == 20'd0))
                            res.status = ST_BAD_FRAME;
                    end
                end
                PCI_CONSECUTIVE:
                begin
                    res.frame_type  = FT_CONSECUTIVE;
                    res.data_offset = OFF_SHORT;
                    res.data_length = 32'(len - 7'd1);
                    res.seq_num     = nib;
                    if (len <= 7'd1)
                        res.status = ST_BAD_FRAME;
                end
                PCI_FLOW:
                begin
                    res.frame_type      = FT_FLOW;
                    res.data_offset     = OFF_FLOW;
                    res.fc_status       = nib[1:0];
                    res.fc_block_limit  = frame.header_byte1;
                    res.separation_time = frame.header_byte2;
                    if ((len < 7'd3) || (nib > FS_MAX) || !stmin_ok)
                        res.status = ST_BAD_FRAME;
                end
                default:
                begin
                    res.status = ST_BAD_FRAME;
                end
            endcase
        end

        if (res.status != ST_OK)
        begin
            res.frame_type      = FT_SINGLE;
            res.data_offset     = '0;
            res.data_length     = '0;
            res.seq_num         = '0;
            res.fc_status       = '0;
            res.fc_block_limit  = '0;
            res.separation_time = '0;
        end
    end

    assign result = res;

endmodule

/* src/isotp_pci_header_decoder.sv */
// ----------------------------------------------------------------------------
// ISO-TP PCI header decoder
// Decodes the protocol control information of one CAN or CAN FD frame.
// ----------------------------------------------------------------------------
// The frame channel carries the frame length and the first six frame bytes.
// The result channel carries the status, frame type, payload offset and
// length, and the fields that belong to the frame type.
// Both channels use valid/ready; a transfer happens when both are high.
// An accepted frame is held in an input register, decoded by one level of
// combinational logic and captured in a result register once that register
// is free, and the result register then offers it on the result channel.
// The block takes one frame per cycle while the receiver does not stall;
// frame_ready stays high while the input register is empty or the result
// register is empty or being drained in the same cycle.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and frame_ready then drops until the result is taken.
// Reset clears both stage valid flags; no result is offered after reset.
// MAX_FRAME_BYTES sets the largest frame length that is accepted as valid.
// ----------------------------------------------------------------------------
module isotp_pci_header_decoder #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  isotp_pci_pkg::frame_t  frame,
    output logic                   result_valid,
    input  logic                   result_ready,
    output isotp_pci_pkg::result_t result
);
    import isotp_pci_pkg::*;

    frame_t  frame_reg;
    logic    stage_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    stage_advance;
    logic    result_free;

    assign result_free   = !result_valid_reg || result_ready;
    assign stage_advance = stage_valid_reg && result_free;
    assign frame_ready   = !stage_valid_reg || stage_advance;

    isotp_pci_decode #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_decode (
        .frame (frame_reg),
        .result(result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_ready)
                stage_valid_reg <= frame_valid;
            if (result_free)
                result_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
            frame_reg <= frame;
        if (stage_advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) |=> stage_valid_reg)
        else $error("accepted frame did not reach the input register");

    a_stage_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        stage_advance |=> result_valid_reg)
        else $error("decoded frame did not reach the result register");

    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status != ST_OK)) |->
        ((result_reg.data_length == 32'd0) && (result_reg.data_offset == 3'd0) &&
         (result_reg.fc_block_limit == 8'd0) && (result_reg.separation_time == 8'd0)))
        else $error("error result carries nonzero fields");

    a_consecutive_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status == ST_OK) &&
         (result_reg.frame_type == FT_CONSECUTIVE)) |->
        (result_reg.data_offset == OFF_SHORT))
        else $error("consecutive frame with wrong payload offset");

endmodule
